// File: sv/multi_level_cpu_execute_core_unit_defines.svh
// ---------------------------------------------------------------------------
// assertion macros for the execute core
// shared checks written as concurrent properties
// ---------------------------------------------------------------------------
`ifndef MULTI_LEVEL_CPU_EXECUTE_CORE_UNIT_DEFINES_SVH
`define MULTI_LEVEL_CPU_EXECUTE_CORE_UNIT_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define MLC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define MLC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/mlc_pkg.sv
// ---------------------------------------------------------------------------
// mlc_pkg
// types, codes and constants of the execute core
// ---------------------------------------------------------------------------
package mlc_pkg;

    localparam int MaxLevels = 4;
    localparam int LvW = 2;

    localparam logic [2:0] ACT_BEGIN = 3'd0;
    localparam logic [2:0] ACT_BUS   = 3'd1;
    localparam logic [2:0] ACT_RREAD = 3'd2;
    localparam logic [2:0] ACT_RWRITE = 3'd3;
    localparam logic [2:0] ACT_IRQ   = 3'd4;

    localparam logic [2:0] K_FETCH   = 3'd0;
    localparam logic [2:0] K_READW   = 3'd1;
    localparam logic [2:0] K_READB   = 3'd2;
    localparam logic [2:0] K_WRITEW  = 3'd3;
    localparam logic [2:0] K_WRITEB  = 3'd4;
    localparam logic [2:0] K_DONE    = 3'd5;
    localparam logic [2:0] K_UNDEF   = 3'd6;
    localparam logic [2:0] K_REGDATA = 3'd7;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_FETCH   = 2'd1;
    localparam logic [1:0] PH_OPERAND = 2'd2;
    localparam logic [1:0] PH_TARGET  = 2'd3;

    localparam logic [3:0] OP_LOAD  = 4'd0;
    localparam logic [3:0] OP_ADD   = 4'd1;
    localparam logic [3:0] OP_SUB   = 4'd2;
    localparam logic [3:0] OP_CMP   = 4'd3;
    localparam logic [3:0] OP_AND   = 4'd4;
    localparam logic [3:0] OP_XOR   = 4'd5;
    localparam logic [3:0] OP_OR    = 4'd6;
    localparam logic [3:0] OP_MLT   = 4'd7;
    localparam logic [3:0] OP_STORE = 4'd8;
    localparam logic [3:0] OP_NONE  = 4'd15;

    localparam logic [3:0] SEL_P = 4'd2;
    localparam logic [3:0] SEL_A = 4'd4;
    localparam logic [3:0] SEL_R = 4'd6;
    localparam logic [3:0] SEL_S = 4'd8;
    localparam logic [3:0] SEL_T = 4'd10;
    localparam logic [3:0] SEL_F = 4'd12;

    localparam logic [15:0] P_RESET = 16'h8000;
    localparam logic [7:0] LSI_CLRK = 8'h20;
    localparam logic [7:0] LSI_SETK = 8'h21;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] bus_data;
        logic [7:0]  reg_address;
        logic [15:0] reg_data;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] address;
        logic [15:0] write_data;
        logic [15:0] read_data;
        logic        ends_instruction;
    } out_item_t;

    // one level's register bank
    typedef struct packed {
        logic [15:0] p;
        logic [15:0] a;
        logic [15:0] r;
        logic [15:0] s;
        logic [15:0] t;
        logic [2:0]  f;
    } bank_t;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] dst;
    } mdec_t;

    function automatic mdec_t decode_mem(input logic [7:0] msi);
        mdec_t d;
        d.dst = msi[4:3];
        d.op = OP_NONE;
        if (msi < 8'h20) d.op = OP_LOAD;
        else if (msi < 8'h40) d.op = OP_STORE;
        else if (msi < 8'h60) d.op = OP_ADD;
        else if (msi < 8'h80) d.op = OP_CMP;
        else begin
            d.dst = {1'b0, msi[3]};
            if (msi < 8'h90) d.op = OP_SUB;
            else if (msi < 8'hA0) d.op = OP_AND;
            else if (msi < 8'hB0) d.op = OP_XOR;
            else if (msi < 8'hC0) d.op = OP_OR;
            else if (msi >= 8'hD8 && msi < 8'hE0) begin
                d.op = OP_MLT;
                d.dst = 2'd0;
            end
        end
        return d;
    endfunction

endpackage

// File: sv/mlc_alu.sv
// ---------------------------------------------------------------------------
// mlc_alu
// applies an arithmetic or logic op to one bank, 17-bit signed operand
// ---------------------------------------------------------------------------
module mlc_alu (
    input  logic [3:0]          op,
    input  logic [1:0]          dst,
    input  logic signed [16:0]  opnd,
    input  mlc_pkg::bank_t      bank_in,
    output mlc_pkg::bank_t      bank_out
);
    import mlc_pkg::*;

    logic [15:0]        cur_u;
    logic signed [17:0] sum;
    logic [15:0]        res;
    logic signed [33:0] prod;
    logic signed [16:0] cur_s;

    always_comb begin
        case (dst)
            2'd0:    cur_u = bank_in.a;
            2'd1:    cur_u = bank_in.r;
            2'd2:    cur_u = bank_in.s;
            default: cur_u = bank_in.t;
        endcase
    end

    assign cur_s = {cur_u[15], cur_u};
    assign prod  = 34'(signed'(bank_in.a)) * 34'(opnd);

    always_comb begin
        bank_out = bank_in;
        res = cur_u;
        sum = '0;
        case (op)
            OP_LOAD: begin
                res = opnd[15:0];
                if (dst != 2'd3) begin
                    bank_out.f[2] = (res == 16'd0);
                    bank_out.f[1] = res[15];
                end
            end
            OP_ADD, OP_SUB: begin
                sum = (op == OP_ADD) ? 18'(cur_s) + 18'(opnd) : 18'(cur_s) - 18'(opnd);
                res = sum[15:0];
                bank_out.f[2] = sum[16];
                bank_out.f[1] = (sum > 18'sd32767) || (sum < -18'sd32768);
            end
            OP_CMP: begin
                bank_out.f[2] = (cur_s == opnd);
                bank_out.f[1] = (cur_s < opnd);
            end
            OP_AND: res = cur_u & opnd[15:0];
            OP_XOR: res = cur_u ^ opnd[15:0];
            OP_OR:  res = cur_u | opnd[15:0];
            default: ;
        endcase
        if (op == OP_MLT) begin
            bank_out.a = prod[30:15];
            bank_out.r = {prod[14:0], 1'b0};
        end else if (op != OP_CMP) begin
            case (dst)
                2'd0:    bank_out.a = res;
                2'd1:    bank_out.r = res;
                2'd2:    bank_out.s = res;
                default: bank_out.t = res;
            endcase
        end
    end
endmodule

// File: sv/mlc_shifter.sv
// ---------------------------------------------------------------------------
// mlc_shifter
// shift group: left, logical right, arithmetic right, coupled through c
// ---------------------------------------------------------------------------
module mlc_shifter (
    input  logic [7:0]     lsi,
    input  logic [1:0]     dst,
    input  mlc_pkg::bank_t bank_in,
    output mlc_pkg::bank_t bank_out,
    output logic           undef
);
    import mlc_pkg::*;

    logic [15:0] v;
    logic [4:0]  sh;
    logic        coupled;
    logic        arith;
    logic [31:0] w;
    logic [15:0] u;
    logic        c;

    always_comb begin
        case (dst)
            2'd0:    v = bank_in.a;
            2'd1:    v = bank_in.r;
            2'd2:    v = bank_in.s;
            default: v = bank_in.t;
        endcase
        arith   = lsi[4];
        coupled = (lsi[3:0] == 4'd0);
        sh      = coupled ? 5'd1 : {1'b0, lsi[3:0]};
        undef   = coupled && arith;
        if (!lsi[5]) begin
            w = {16'd0, v} << sh;
            c = w[16];
            u = w[15:0];
            if (coupled && bank_in.f[2]) u[0] = 1'b1;
        end else begin
            w = {{16{v[15]}}, v};
            w = 32'($signed(w) >>> (sh - 5'd1));
            c = w[0];
            u = w[16:1];
            if (!arith) u = u & (16'hFFFF >> sh);
            if (coupled && bank_in.f[2]) u[15] = 1'b1;
        end
        bank_out = bank_in;
        bank_out.f[2] = c;
        case (dst)
            2'd0:    bank_out.a = u;
            2'd1:    bank_out.r = u;
            2'd2:    bank_out.s = u;
            default: bank_out.t = u;
        endcase
    end
endmodule

// File: sv/multi_level_cpu_execute_core_unit.sv
// an accepted request that has a result puts it in the output register in the next cycle
// throughput: one request per cycle while s_ready is high; all work is one pass of logic from the bank registers
// a result waiting in the output register does not block intake while m_ready is high
// reset: synchronous active low; level 1, p of level 1 at 0x8000, all else zero
// ---------------------------------------------------------------------------
// multi_level_cpu_execute_core_unit
// 16-bit core with per-level register banks, stepped one bus event at a time
// ---------------------------------------------------------------------------
module multi_level_cpu_execute_core_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mlc_pkg::in_item_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mlc_pkg::out_item_t   m_data
);
    import mlc_pkg::*;
    `include "multi_level_cpu_execute_core_unit_defines.svh"

    // architectural state
    logic               two_levels_reg;
    logic [1:0]         phase_reg, phase_next;
    logic [15:0]        held_reg, held_next;
    logic [1:0]         level_reg, level_next;
    logic               pend_reg, pend_next;
    logic [15:0]        ret_reg, ret_next;
    bank_t              bank_reg [MaxLevels];
    bank_t              wb_bank;
    logic               wb_en;
    logic [LvW-1:0]     wb_lv;

    // output register
    logic               m_valid_reg;
    out_item_t          m_data_reg;
    logic               emit;
    out_item_t          res;

    logic               accept;
    in_item_t           in;
    logic [2:0]         nlev;
    bank_t              cb;
    logic [LvW-1:0]     lv;
    logic [7:0]         msi, lsi;
    logic               word, neg;
    mdec_t              md, hmd;
    logic [15:0]        base, ea, tgt, xv;
    logic [7:0]         off;
    logic               cond;

    // alu and shifter hookup
    logic [3:0]         alu_op;
    logic [1:0]         alu_dst;
    logic signed [16:0] alu_opnd;
    bank_t              alu_out, sh_out;
    logic               sh_undef;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign in      = s_data;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign nlev    = two_levels_reg ? 3'd2 : 3'(MaxLevels);

    // current bank, level kept in range
    assign lv  = level_reg[LvW-1:0];
    assign cb  = bank_reg[lv];
    assign msi = in.bus_data[15:8];
    assign lsi = in.bus_data[7:0];
    assign word = !lsi[0];
    assign neg  = msi[0];
    assign md  = decode_mem(msi);
    assign hmd = decode_mem(held_reg[15:8]);

    always_comb begin
        case (msi[2:1])
            2'd0:    base = cb.p;
            2'd1:    base = cb.r;
            2'd2:    base = cb.s;
            default: base = cb.t;
        endcase
        case (md.dst)
            2'd0:    xv = cb.a;
            2'd1:    xv = cb.r;
            2'd2:    xv = cb.s;
            default: xv = cb.t;
        endcase
        off = word ? lsi : {1'b0, lsi[7:1]};
        ea  = neg ? base - 16'(off) : base + 16'(off);
        tgt = neg ? (msi >= 8'hD0 ? cb.p : base) - 16'({lsi[7:1], 1'b0})
                  : (msi >= 8'hD0 ? cb.p : base) + 16'({lsi[7:1], 1'b0});
        case (msi[3:1])
            3'd0:    cond = cb.f[1];
            3'd1:    cond = !cb.f[1];
            3'd2:    cond = cb.f[2];
            3'd3:    cond = !cb.f[2];
            default: cond = 1'b1;
        endcase
        if (msi < 8'hD0) cond = 1'b1;
    end

    // alu operand select: literal on fetch, bus data on operand return
    always_comb begin
        if (phase_reg == PH_OPERAND) begin
            alu_op   = hmd.op;
            alu_dst  = hmd.dst;
            alu_opnd = !held_reg[0] ? {in.bus_data[15], in.bus_data}
                                    : {9'd0, in.bus_data[7:0]};
        end else begin
            alu_op   = {1'b0, msi[2:0]};
            alu_dst  = msi[4:3];
            alu_opnd = {9'd0, lsi};
        end
    end

    mlc_alu u_alu (
        .op       (alu_op),
        .dst      (alu_dst),
        .opnd     (alu_opnd),
        .bank_in  (cb),
        .bank_out (alu_out)
    );

    mlc_shifter u_shift (
        .lsi      (lsi),
        .dst      (msi[4:3]),
        .bank_in  (cb),
        .bank_out (sh_out),
        .undef    (sh_undef)
    );

    // next-state and result logic for one request
    always_comb begin
        phase_next = phase_reg;
        held_next  = held_reg;
        level_next = level_reg;
        pend_next  = pend_reg;
        ret_next   = ret_reg;
        wb_en      = 1'b0;
        wb_lv      = lv;
        wb_bank    = cb;
        emit       = 1'b0;
        res        = '0;
        res.ends_instruction = 1'b1;
        case (in.action)
            ACT_BEGIN: begin
                if (phase_reg == PH_IDLE) begin
                    emit = 1'b1;
                    if ({1'b0, level_reg} >= nlev) begin
                        res.kind = K_UNDEF;
                    end else begin
                        // level-1 interrupt entry
                        if (pend_reg && level_reg == 2'd0 && !bank_reg[0].f[0]) begin
                            level_next = 2'd1;
                            pend_next  = 1'b0;
                            wb_lv      = LvW'(1);
                            wb_bank    = bank_reg[1];
                        end
                        res.kind    = K_FETCH;
                        res.address = wb_bank.p;
                        res.ends_instruction = 1'b0;
                        ret_next    = wb_bank.p + 16'd2;
                        wb_bank.p   = ret_next;
                        wb_en       = 1'b1;
                        phase_next  = PH_FETCH;
                    end
                end
            end
            ACT_BUS: begin
                if (phase_reg == PH_FETCH) begin
                    emit = 1'b1;
                    held_next  = in.bus_data;
                    phase_next = PH_IDLE;
                    res.kind   = K_DONE;
                    if (md.op != OP_NONE) begin
                        if (md.op == OP_STORE) begin
                            res.kind       = word ? K_WRITEW : K_WRITEB;
                            res.address    = ea;
                            res.write_data = word ? xv : {8'd0, xv[7:0]};
                        end else begin
                            res.kind    = word ? K_READW : K_READB;
                            res.address = ea;
                            res.ends_instruction = 1'b0;
                            phase_next  = PH_OPERAND;
                        end
                    end else if (msi < 8'hD8) begin
                        // jump group
                        if (cond) begin
                            if (!word) begin
                                res.kind    = K_READW;
                                res.address = tgt;
                                res.ends_instruction = 1'b0;
                                phase_next  = PH_TARGET;
                            end else begin
                                wb_en = 1'b1;
                                wb_bank.p = tgt;
                                if (msi >= 8'hC8 && msi < 8'hD0) wb_bank.s = ret_reg;
                            end
                        end
                    end else if (msi[2:0] != 3'd7) begin
                        wb_en = 1'b1;
                        wb_bank = alu_out;
                    end else if (lsi[7:6] == 2'b01) begin
                        if (sh_undef) res.kind = K_UNDEF;
                        else begin
                            wb_en = 1'b1;
                            wb_bank = sh_out;
                        end
                    end else if (msi == 8'hFF) begin
                        if ({1'b0, lsi} < {6'd0, nlev}) level_next = lsi[1:0];
                        else if (lsi == LSI_CLRK) begin
                            wb_en = 1'b1;
                            wb_bank.f[0] = 1'b0;
                        end else if (lsi == LSI_SETK) begin
                            wb_en = 1'b1;
                            wb_bank.f[0] = 1'b1;
                        end else if (lsi != 8'hFF) res.kind = K_UNDEF;
                    end
                end else if (phase_reg == PH_OPERAND) begin
                    emit = 1'b1;
                    phase_next = PH_IDLE;
                    res.kind = K_DONE;
                    if (hmd.op != OP_NONE && hmd.op != OP_STORE) begin
                        wb_en = 1'b1;
                        wb_bank = alu_out;
                    end
                end else if (phase_reg == PH_TARGET) begin
                    emit = 1'b1;
                    phase_next = PH_IDLE;
                    res.kind = K_DONE;
                    wb_en = 1'b1;
                    wb_bank.p = in.bus_data;
                    if (held_reg[15:8] >= 8'hC8 && held_reg[15:8] < 8'hD0)
                        wb_bank.s = ret_reg;
                end
            end
            ACT_RREAD: begin
                emit = 1'b1;
                res.kind = K_REGDATA;
                res.ends_instruction = 1'b0;
                res.read_data = 16'hFFFF;
                if (in.reg_address == 8'd0) begin
                    res.read_data = {11'd0, pend_reg, 2'd0, level_reg};
                end else if ({1'b0, in.reg_address[7:4]} < {2'd0, nlev}) begin
                    case (in.reg_address[3:0])
                        SEL_P: res.read_data = bank_reg[in.reg_address[5:4]].p;
                        SEL_A: res.read_data = bank_reg[in.reg_address[5:4]].a;
                        SEL_R: res.read_data = bank_reg[in.reg_address[5:4]].r;
                        SEL_S: res.read_data = bank_reg[in.reg_address[5:4]].s;
                        SEL_T: res.read_data = bank_reg[in.reg_address[5:4]].t;
                        SEL_F: res.read_data = {13'd0, bank_reg[in.reg_address[5:4]].f};
                        default: ;
                    endcase
                end
            end
            ACT_RWRITE: begin
                if ({1'b0, in.reg_address[7:4]} < {2'd0, nlev}) begin
                    wb_lv = in.reg_address[5:4];
                    wb_bank = bank_reg[in.reg_address[5:4]];
                    wb_en = 1'b1;
                    case (in.reg_address[3:0])
                        SEL_P: wb_bank.p = in.reg_data;
                        SEL_A: wb_bank.a = in.reg_data;
                        SEL_R: wb_bank.r = in.reg_data;
                        SEL_S: wb_bank.s = in.reg_data;
                        SEL_T: wb_bank.t = in.reg_data;
                        SEL_F: wb_bank.f = in.reg_data[2:0];
                        default: wb_en = 1'b0;
                    endcase
                end
            end
            ACT_IRQ: pend_next = 1'b1;
            default: ;
        endcase
    end

    // state and bank registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            two_levels_reg <= 1'b0;
            phase_reg      <= PH_IDLE;
            held_reg       <= '0;
            level_reg      <= 2'd1;
            pend_reg       <= 1'b0;
            ret_reg        <= '0;
            for (int i = 0; i < MaxLevels; i++) begin
                bank_reg[i]   <= '0;
            end
            bank_reg[1].p  <= P_RESET;
        end else begin
            if (cfg_we) two_levels_reg <= cfg_wdata;
            if (accept) begin
                phase_reg <= phase_next;
                held_reg  <= held_next;
                level_reg <= level_next;
                pend_reg  <= pend_next;
                ret_reg   <= ret_next;
                if (wb_en) bank_reg[wb_lv] <= wb_bank;
            end
        end
    end

    // result register, refilled while the old result is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= accept && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) m_data_reg <= res;
    end

    // an issued fetch is followed by the fetch phase
    `MLC_ASSERT_NEXT(a_fetch_phase, aclk, aresetn,
        accept && emit && res.kind == K_FETCH, phase_reg == PH_FETCH, "fetch without fetch phase")
    // a stalled result holds
    `MLC_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data), "stalled result changed")
    // an empty output register never blocks intake
    `MLC_ASSERT_IMP(a_ready, aclk, aresetn, !m_valid, s_ready, "ready low with empty output")
endmodule

// File: test/tb_multi_level_cpu_execute_core_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_multi_level_cpu_execute_core_unit
// self-checking bench: each accepted request goes through a behavioral copy
// of the core and the expected response is matched against the result port
// ---------------------------------------------------------------------------
module tb_multi_level_cpu_execute_core_unit;
    import mlc_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int CYCLE_LIMIT = 800000;
    localparam int RANDOM_REQUESTS = 1400;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_data;

    // behavioral copy of the core state
    logic        mdl_two_levels;
    logic [1:0]  mdl_phase;
    logic [15:0] mdl_held;
    logic [1:0]  mdl_level;
    logic        mdl_pending;
    logic [15:0] mdl_p [4];
    logic [15:0] mdl_a [4];
    logic [15:0] mdl_r [4];
    logic [15:0] mdl_s [4];
    logic [15:0] mdl_t [4];
    logic [2:0]  mdl_f [4];
    logic [15:0] mdl_ret;

    out_item_t expected_responses[$];
    int        fail_count = 0;
    int        cycle_count = 0;
    int        sent_count = 0;
    int        burst_left = 0;
    int        stall_mode = 0;

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    multi_level_cpu_execute_core_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // ---------------------------------------------------------------------
    // core behavior
    // ---------------------------------------------------------------------
    function automatic int level_count();
        return mdl_two_levels ? 2 : 4;
    endfunction

    function automatic logic [15:0] get_x(int lv, logic [1:0] k);
        case (k)
            2'd0: return mdl_a[lv];
            2'd1: return mdl_r[lv];
            2'd2: return mdl_s[lv];
            default: return mdl_t[lv];
        endcase
    endfunction

    function automatic void set_x(int lv, logic [1:0] k, logic [15:0] v);
        case (k)
            2'd0: mdl_a[lv] = v;
            2'd1: mdl_r[lv] = v;
            2'd2: mdl_s[lv] = v;
            default: mdl_t[lv] = v;
        endcase
    endfunction

    // base register: p stands in for a
    function automatic logic [15:0] get_base(int lv, logic [1:0] k);
        return (k == 2'd0) ? mdl_p[lv] : get_x(lv, k);
    endfunction

    function automatic void set_cv(int lv, logic c, logic v);
        mdl_f[lv] = {c, v, mdl_f[lv][0]};
    endfunction

    function automatic logic [15:0] offset_address(logic [15:0] base, logic neg,
                                                   logic [15:0] off);
        return neg ? base - off : base + off;
    endfunction

    function automatic out_item_t response(logic [2:0] kind, logic [15:0] addr,
                                           logic [15:0] wd, logic [15:0] rd,
                                           logic ends);
        out_item_t o;
        o.kind = kind;
        o.address = addr;
        o.write_data = wd;
        o.read_data = rd;
        o.ends_instruction = ends;
        return o;
    endfunction

    // memory operand groups
    function automatic void mem_decode(input logic [7:0] msi, output logic [3:0] op,
                                       output logic [1:0] dst);
        dst = msi[4:3];
        op = OP_NONE;
        if (msi < 8'h20) op = OP_LOAD;
        else if (msi < 8'h40) op = OP_STORE;
        else if (msi < 8'h60) op = OP_ADD;
        else if (msi < 8'h80) op = OP_CMP;
        else begin
            dst = {1'b0, msi[3]};
            if (msi < 8'h90) op = OP_SUB;
            else if (msi < 8'hA0) op = OP_AND;
            else if (msi < 8'hB0) op = OP_XOR;
            else if (msi < 8'hC0) op = OP_OR;
            else if (msi >= 8'hD8 && msi < 8'hE0) begin
                op = OP_MLT;
                dst = 2'd0;
            end
        end
    endfunction

    function automatic void alu_apply(int lv, logic [3:0] op, logic [1:0] dst, int opnd);
        logic [15:0] rv;
        int          cur;
        int          sum;
        longint      prod;
        rv = get_x(lv, dst);
        cur = int'($signed(rv));
        case (op)
            OP_LOAD: begin
                rv = opnd[15:0];
                set_x(lv, dst, rv);
                if (dst != 2'd3) set_cv(lv, rv == 16'd0, rv[15]);
            end
            OP_ADD, OP_SUB: begin
                sum = (op == OP_ADD) ? cur + opnd : cur - opnd;
                set_x(lv, dst, sum[15:0]);
                set_cv(lv, sum[16], sum > 32767 || sum < -32768);
            end
            OP_CMP: set_cv(lv, cur == opnd, cur < opnd);
            OP_AND: set_x(lv, dst, rv & opnd[15:0]);
            OP_XOR: set_x(lv, dst, rv ^ opnd[15:0]);
            OP_OR:  set_x(lv, dst, rv | opnd[15:0]);
            default: begin
                prod = longint'($signed(mdl_a[lv])) * longint'(opnd) * 2;
                mdl_a[lv] = prod[31:16];
                mdl_r[lv] = prod[15:0];
            end
        endcase
    endfunction

    // shifts and the 0xff specials; 0 means an undefined form
    function automatic bit shift_or_special(int lv, logic [7:0] msi, logic [7:0] lsi);
        logic [15:0] rv;
        logic [31:0] u;
        logic        old_c;
        logic        arith;
        logic        coupled;
        logic        c;
        int          sh;
        if (lsi[7:6] == 2'b01) begin
            rv = get_x(lv, msi[4:3]);
            old_c = mdl_f[lv][2];
            arith = lsi[4];
            sh = int'(lsi[3:0]);
            coupled = 1'b0;
            if (sh == 0) begin
                if (arith) return 0;
                coupled = 1'b1;
                sh = 1;
            end
            if (!lsi[5]) begin
                u = ({16'd0, rv} << (sh - 1)) & 32'hFFFF;
                c = u[15];
                u = (u << 1) & 32'hFFFF;
                if (coupled && old_c) u[0] = 1'b1;
            end else begin
                u = {{16{rv[15]}}, rv};
                u = u >> (sh - 1);
                c = u[0];
                u = (u >> 1) & 32'hFFFF;
                if (!arith) u = u & (32'hFFFF >> sh);
                if (coupled && old_c) u[15] = 1'b1;
            end
            set_x(lv, msi[4:3], u[15:0]);
            mdl_f[lv][2] = c;
            return 1;
        end
        if (msi != 8'hFF) return 1;
        if (int'(lsi) < level_count()) mdl_level = lsi[1:0];
        else if (lsi == LSI_CLRK) mdl_f[lv][0] = 1'b0;
        else if (lsi == LSI_SETK) mdl_f[lv][0] = 1'b1;
        else if (lsi != 8'hFF) return 0;
        return 1;
    endfunction

    // instruction word just fetched
    function automatic out_item_t decode_instruction(logic [15:0] ins);
        int          lv;
        logic [7:0]  msi;
        logic [7:0]  lsi;
        logic        neg;
        logic        word;
        logic [3:0]  op;
        logic [1:0]  dst;
        logic [15:0] ea;
        logic [15:0] v;
        logic        cond;
        logic [1:0]  yk;
        lv = int'(mdl_level);
        msi = ins[15:8];
        lsi = ins[7:0];
        neg = msi[0];
        word = !lsi[0];
        mdl_held = ins;
        mdl_phase = PH_IDLE;
        mem_decode(msi, op, dst);
        if (op != OP_NONE) begin
            ea = offset_address(get_base(lv, msi[2:1]), neg,
                                word ? {8'd0, lsi} : {9'd0, lsi[7:1]});
            if (op == OP_STORE) begin
                v = get_x(lv, dst);
                return word ? response(K_WRITEW, ea, v, 16'd0, 1'b1)
                            : response(K_WRITEB, ea, {8'd0, v[7:0]}, 16'd0, 1'b1);
            end
            mdl_phase = PH_OPERAND;
            return response(word ? K_READW : K_READB, ea, 16'd0, 16'd0, 1'b0);
        end
        if (msi >= 8'hC0 && msi < 8'hD8) begin
            // jumps: conditional forms test v or c
            cond = 1'b1;
            yk = (msi < 8'hD0) ? msi[2:1] : 2'd0;
            case ({msi[7:1], 1'b0})
                8'hD0: cond = mdl_f[lv][1];
                8'hD2: cond = !mdl_f[lv][1];
                8'hD4: cond = mdl_f[lv][2];
                8'hD6: cond = !mdl_f[lv][2];
                default: ;
            endcase
            if (!cond) return response(K_DONE, 16'd0, 16'd0, 16'd0, 1'b1);
            ea = offset_address(get_base(lv, yk), neg, {8'd0, lsi[7:1], 1'b0});
            if (!word) begin
                mdl_phase = PH_TARGET;
                return response(K_READW, ea, 16'd0, 16'd0, 1'b0);
            end
            mdl_p[lv] = ea;
            if (msi >= 8'hC8 && msi < 8'hD0) mdl_s[lv] = mdl_ret;
            return response(K_DONE, 16'd0, 16'd0, 16'd0, 1'b1);
        end
        // literal group
        if (msi[2:0] != 3'd7) begin
            alu_apply(lv, {1'b0, msi[2:0]}, msi[4:3], int'(lsi));
            return response(K_DONE, 16'd0, 16'd0, 16'd0, 1'b1);
        end
        if (!shift_or_special(lv, msi, lsi))
            return response(K_UNDEF, 16'd0, 16'd0, 16'd0, 1'b1);
        return response(K_DONE, 16'd0, 16'd0, 16'd0, 1'b1);
    endfunction

    // one accepted request; returns 1 with the response it must produce
    function automatic bit predict_core_response(in_item_t it, output out_item_t o);
        int         lv;
        int         ul;
        logic [3:0] sel;
        logic [3:0] op;
        logic [1:0] dst;
        o = '0;
        lv = int'(mdl_level);
        ul = int'(it.reg_address[7:4]);
        sel = it.reg_address[3:0];
        case (it.action)
            ACT_BEGIN: begin
                if (mdl_phase != PH_IDLE) return 0;
                if (int'(mdl_level) >= level_count()) begin
                    o = response(K_UNDEF, 16'd0, 16'd0, 16'd0, 1'b1);
                    return 1;
                end
                if (mdl_pending && mdl_level == 2'd0 && !mdl_f[0][0]) begin
                    mdl_level = 2'd1;
                    mdl_pending = 1'b0;
                end
                lv = int'(mdl_level);
                o = response(K_FETCH, mdl_p[lv], 16'd0, 16'd0, 1'b0);
                mdl_ret = mdl_p[lv] + 16'd2;
                mdl_p[lv] = mdl_ret;
                mdl_phase = PH_FETCH;
                return 1;
            end
            ACT_BUS: begin
                case (mdl_phase)
                    PH_FETCH: o = decode_instruction(it.bus_data);
                    PH_OPERAND: begin
                        mdl_phase = PH_IDLE;
                        mem_decode(mdl_held[15:8], op, dst);
                        if (op != OP_NONE && op != OP_STORE)
                            alu_apply(lv, op, dst, mdl_held[0] ? int'(it.bus_data[7:0])
                                                               : int'($signed(it.bus_data)));
                        o = response(K_DONE, 16'd0, 16'd0, 16'd0, 1'b1);
                    end
                    PH_TARGET: begin
                        mdl_phase = PH_IDLE;
                        mdl_p[lv] = it.bus_data;
                        if (mdl_held[15:8] >= 8'hC8 && mdl_held[15:8] < 8'hD0)
                            mdl_s[lv] = mdl_ret;
                        o = response(K_DONE, 16'd0, 16'd0, 16'd0, 1'b1);
                    end
                    default: return 0;
                endcase
                return 1;
            end
            ACT_RREAD: begin
                o = response(K_REGDATA, 16'd0, 16'd0, 16'hFFFF, 1'b0);
                if (it.reg_address == 8'd0)
                    o.read_data = {11'd0, mdl_pending, 2'd0, mdl_level};
                else if (ul < level_count()) begin
                    case (sel)
                        SEL_P: o.read_data = mdl_p[ul];
                        SEL_A: o.read_data = mdl_a[ul];
                        SEL_R: o.read_data = mdl_r[ul];
                        SEL_S: o.read_data = mdl_s[ul];
                        SEL_T: o.read_data = mdl_t[ul];
                        SEL_F: o.read_data = {13'd0, mdl_f[ul]};
                        default: ;
                    endcase
                end
                return 1;
            end
            ACT_RWRITE: begin
                if (ul < level_count()) begin
                    case (sel)
                        SEL_P: mdl_p[ul] = it.reg_data;
                        SEL_A: mdl_a[ul] = it.reg_data;
                        SEL_R: mdl_r[ul] = it.reg_data;
                        SEL_S: mdl_s[ul] = it.reg_data;
                        SEL_T: mdl_t[ul] = it.reg_data;
                        SEL_F: mdl_f[ul] = it.reg_data[2:0];
                        default: ;
                    endcase
                end
                return 0;
            end
            ACT_IRQ: begin
                mdl_pending = 1'b1;
                return 0;
            end
            default: return 0;
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // request driver, shared by all tests
    // ---------------------------------------------------------------------
    task automatic send_request(input in_item_t it);
        out_item_t o;
        s_data <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
        if (predict_core_response(it, o)) expected_responses.push_back(o);
        // bursts of back-to-back requests, then a random gap
        if (burst_left > 0) burst_left--;
        else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(0, 12);
        end
    endtask

    function automatic in_item_t request(logic [2:0] action, logic [15:0] bus,
                                         logic [7:0] ra, logic [15:0] rd);
        in_item_t it;
        it.action = action;
        it.bus_data = bus;
        it.reg_address = ra;
        it.reg_data = rd;
        return it;
    endfunction

    // begin, instruction word, then operand or target word if asked for
    task automatic run_instruction(input logic [15:0] ins, input logic [15:0] operand);
        send_request(request(ACT_BEGIN, $urandom, $urandom, $urandom));
        if (mdl_phase == PH_FETCH)
            send_request(request(ACT_BUS, ins, $urandom, $urandom));
        if (mdl_phase != PH_IDLE)
            send_request(request(ACT_BUS, operand, $urandom, $urandom));
    endtask

    task automatic port_write(input logic [7:0] ra, input logic [15:0] v);
        send_request(request(ACT_RWRITE, $urandom, ra, v));
    endtask

    task automatic port_read(input logic [7:0] ra);
        send_request(request(ACT_RREAD, $urandom, ra, $urandom));
    endtask

    // drop valid and let every outstanding response drain
    task automatic drain_core();
        s_valid <= 1'b0;
        burst_left = 0;
        while (expected_responses.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_two_levels(input logic v);
        drain_core();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        mdl_two_levels = v;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] random_instruction();
        int pick;
        logic [7:0] msi;
        logic [7:0] lsi;
        pick = $urandom_range(0, 99);
        msi = $urandom;
        lsi = $urandom;
        if (pick < 20) begin
            // shifts on any register
            msi = {3'b111, 2'($urandom), 3'b111};
            lsi = {2'b01, 6'($urandom)};
        end else if (pick < 28) begin
            msi = 8'hFF;
            case ($urandom_range(0, 4))
                0: lsi = 8'($urandom_range(0, 3));
                1: lsi = LSI_CLRK;
                2: lsi = LSI_SETK;
                3: lsi = 8'hFF;
                default: ;
            endcase
        end
        return {msi, lsi};
    endfunction

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------
    task automatic test_register_port();
        port_read(8'h00);
        port_write(8'h24, 16'hFFFF);
        port_read(8'h24);
        port_write(8'h3C, 16'hFFFF);
        port_read(8'h3C);
        port_write(8'h1A, 16'h0000);
        port_read(8'h1A);
        port_read(8'h1E);
        port_read(8'hF2);
    endtask

    task automatic test_instruction_set();
        run_instruction(16'h0000, 16'h8000);   // load a, word from p
        run_instruction(16'hE17F, 16'h0000);   // add literal
        run_instruction(16'h2101, 16'h0000);   // store byte, negative offset
        run_instruction(16'h8002, 16'h7FFF);   // subtract word
        run_instruction(16'h6000, 16'h0000);   // compare
        run_instruction(16'hD800, 16'h8000);   // multiply by minus one
        run_instruction(16'hC811, 16'h1234);   // subroutine call, indirect target
        run_instruction(16'hD404, 16'h0000);   // jump when c set
    endtask

    task automatic test_shifts();
        run_instruction(16'hE300, 16'h0000);   // compare a with 0 sets c when equal
        run_instruction(16'hE760, 16'h0000);   // coupled logical right shift
        run_instruction(16'hE750, 16'h0000);   // arithmetic shift by 0: undefined
        run_instruction(16'hEF4F, 16'h0000);   // left shift by 15
        run_instruction(16'hF77F, 16'h0000);   // arithmetic right shift by 15
    endtask

    task automatic test_specials_and_interrupt();
        run_instruction(16'hFF21, 16'h0000);   // set k
        run_instruction(16'hFF20, 16'h0000);   // clear k
        run_instruction(16'hFFFF, 16'h0000);   // no operation
        run_instruction(16'hFF22, 16'h0000);   // unknown special
        run_instruction(16'hFF00, 16'h0000);   // drop to level 0
        send_request(request(ACT_IRQ, $urandom, $urandom, $urandom));
        port_read(8'h00);
        run_instruction(16'hFFFF, 16'h0000);   // taken into level 1
    endtask

    task automatic test_ignored_requests();
        send_request(request(ACT_BUS, 16'hFFFF, 8'hFF, 16'hFFFF));   // bus while idle
        send_request(request(ACT_BEGIN, 16'h0, 8'h0, 16'h0));
        send_request(request(ACT_BEGIN, 16'h0, 8'h0, 16'h0));        // begin while busy
        send_request(request(3'd5, $urandom, $urandom, $urandom));
        send_request(request(3'd7, $urandom, $urandom, $urandom));
        send_request(request(ACT_BUS, 16'hFFFF, 8'h0, 16'h0));
    endtask

    task automatic test_absent_level();
        run_instruction(16'hFF03, 16'h0000);   // move to level 3
        write_two_levels(1'b1);
        run_instruction(16'h0000, 16'h0000);   // level gone: undefined
        port_write(8'h34, 16'h5555);
        port_read(8'h34);
        write_two_levels(1'b0);
        run_instruction(16'hFF01, 16'h0000);
    endtask

    task automatic test_random_traffic(input int count);
        int stop_at;
        int pick;
        stop_at = sent_count + count;
        while (sent_count < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) run_instruction(random_instruction(), $urandom);
            else if (pick < 78)
                port_read(($urandom_range(0, 3) == 0) ? 8'($urandom)
                          : {4'($urandom_range(0, 3)), 3'($urandom_range(1, 6)), 1'b0});
            else if (pick < 86) port_write($urandom, $urandom);
            else if (pick < 89) send_request(request(ACT_IRQ, $urandom, $urandom, $urandom));
            else if (pick < 95)
                send_request(request(3'($urandom_range(1, 7)), $urandom, $urandom, $urandom));
            else send_request(request(ACT_BEGIN, $urandom, $urandom, $urandom));
        end
    endtask

    // ---------------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_responses.size() == 0) begin
                $error("unexpected response kind %0d", m_data.kind);
                fail_count++;
            end else begin
                want = expected_responses.pop_front();
                if (m_data.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, m_data.kind);
                    fail_count++;
                end
                if (m_data.address !== want.address) begin
                    $error("address: expected %h, got %h", want.address, m_data.address);
                    fail_count++;
                end
                if (m_data.write_data !== want.write_data) begin
                    $error("write_data: expected %h, got %h",
                           want.write_data, m_data.write_data);
                    fail_count++;
                end
                if (m_data.read_data !== want.read_data) begin
                    $error("read_data: expected %h, got %h",
                           want.read_data, m_data.read_data);
                    fail_count++;
                end
                if (m_data.ends_instruction !== want.ends_instruction) begin
                    $error("ends_instruction: expected %0d, got %0d",
                           want.ends_instruction, m_data.ends_instruction);
                    fail_count++;
                end
            end
        end
    end

    // receiver stall pattern: always ready, random ready, or mostly stalled
    always @(posedge aclk) begin
        if (cycle_count % 50 == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom);
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("multi_level_cpu_execute_core_unit regression: fail");
            $finish;
        end
    end

    initial begin
        mdl_two_levels = 1'b0;
        mdl_phase = PH_IDLE;
        mdl_held = '0;
        mdl_level = 2'd1;
        mdl_pending = 1'b0;
        mdl_ret = '0;
        for (int i = 0; i < 4; i++) begin
            mdl_p[i] = '0;
            mdl_a[i] = '0;
            mdl_r[i] = '0;
            mdl_s[i] = '0;
            mdl_t[i] = '0;
            mdl_f[i] = '0;
        end
        mdl_p[1] = P_RESET;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_register_port();
        test_instruction_set();
        test_shifts();
        test_specials_and_interrupt();
        test_ignored_requests();
        test_absent_level();

        test_random_traffic(RANDOM_REQUESTS / 2);
        run_instruction(16'hFF01, 16'h0000);   // level 1 before going down to two
        write_two_levels(1'b1);
        test_random_traffic(RANDOM_REQUESTS / 4);
        write_two_levels(1'b0);
        test_random_traffic(RANDOM_REQUESTS / 4);

        drain_core();
        repeat (5) @(posedge aclk);
        if (fail_count == 0) $display("multi_level_cpu_execute_core_unit regression: pass");
        else $display("multi_level_cpu_execute_core_unit regression: fail");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/mlc_pkg.sv
sv/mlc_alu.sv
sv/mlc_shifter.sv
sv/multi_level_cpu_execute_core_unit.sv
test/tb_multi_level_cpu_execute_core_unit.sv
